// ===== rtl/pfa_pkg.sv =====
// Shared constants, payload words and memory request type for the page frame allocator.
`timescale 1ns / 1ps

package pfa_pkg;

    // Geometry
    localparam int FRAME_COUNT = 64;
    localparam int FRAME_BYTES = 256;
    localparam int FRAME_W     = $clog2(FRAME_COUNT);
    localparam int BYTE_W      = $clog2(FRAME_BYTES);
    localparam int ADDR_W      = FRAME_W + BYTE_W;
    localparam int MEM_DEPTH   = FRAME_COUNT * FRAME_BYTES;
    // Stored values are frame numbers, pointers or in-use flags: one frame index wide
    localparam int DATA_W      = FRAME_W;
    // Byte offset in frame 0 of the per-process table pointers
    localparam int PTR_BASE    = 64;

    // Request codes
    localparam logic [1:0] REQ_NEW  = 2'd0;
    localparam logic [1:0] REQ_KILL = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] proc_id;
        logic [7:0] num_pages;
        logic [7:0] virt_page;
    } t_in_word;

    typedef struct packed {
        logic       status;
        logic [5:0] table_frame;
        logic [5:0] mapped_frame;
    } t_out_word;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// ===== rtl/pfa_mem.sv =====
// Physical memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module pfa_mem (
    input  logic                       i_clk,
    input  pfa_pkg::t_mem_req          i_req,
    output logic [pfa_pkg::DATA_W-1:0] o_rdata
);

    logic [pfa_pkg::DATA_W-1:0] r_mem [pfa_pkg::MEM_DEPTH];
    logic [pfa_pkg::DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pfa_seq.sv =====
// Request sequencer: clearing pass, free map scan, table walks and entry reads.
`timescale 1ns / 1ps

module pfa_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  pfa_pkg::t_in_word          i_in_word,
    output logic                       o_in_stall,
    output logic                       o_res_valid,
    output pfa_pkg::t_out_word         o_res_word,
    input  logic                       i_res_ready,
    output pfa_pkg::t_mem_req          o_mem_req,
    input  logic [pfa_pkg::DATA_W-1:0] i_mem_rdata
);

    localparam int FW = pfa_pkg::FRAME_W;
    localparam int BW = pfa_pkg::BYTE_W;
    localparam int AW = pfa_pkg::ADDR_W;
    localparam int DW = pfa_pkg::DATA_W;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_N_CHK  = 4'd2;
    localparam logic [3:0] S_N_REC  = 4'd3;
    localparam logic [3:0] S_K_PTR  = 4'd4;
    localparam logic [3:0] S_K_CHK  = 4'd5;
    localparam logic [3:0] S_K_CLR  = 4'd6;
    localparam logic [3:0] S_K_FREE = 4'd7;
    localparam logic [3:0] S_R_PTR  = 4'd8;
    localparam logic [3:0] S_R_ENT  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    localparam logic [AW-1:0] LAST_ADDR  = AW'(pfa_pkg::MEM_DEPTH - 1);
    localparam logic [FW-1:0] LAST_FRAME = FW'(pfa_pkg::FRAME_COUNT - 1);
    localparam logic [BW-1:0] LAST_BYTE  = BW'(pfa_pkg::FRAME_BYTES - 1);

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [FW-1:0] r_cur, n_cur;
    logic [BW-1:0] r_idx, n_idx;
    logic [FW-1:0] r_tab, n_tab;
    logic          r_tphase, n_tphase;
    logic [5:0]    r_proc, n_proc;
    logic [7:0]    r_count, n_count;
    logic [7:0]    r_vpage, n_vpage;
    logic          r_status, n_status;
    logic [5:0]    r_tframe, n_tframe;
    logic [5:0]    r_mframe, n_mframe;

    logic [AW-1:0] w_ptr_in;
    logic [AW-1:0] w_ptr_cur;
    logic [FW-1:0] w_cur_nx;
    logic          w_pages_done;

    // Pointer byte addresses in frame 0
    assign w_ptr_in  = AW'(pfa_pkg::PTR_BASE) + AW'(i_in_word.proc_id);
    assign w_ptr_cur = AW'(pfa_pkg::PTR_BASE) + AW'(r_proc);
    assign w_cur_nx  = r_cur + 1'b1;

    // Next state and memory port
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_cur        = r_cur;
        n_idx        = r_idx;
        n_tab        = r_tab;
        n_tphase     = r_tphase;
        n_proc       = r_proc;
        n_count      = r_count;
        n_vpage      = r_vpage;
        n_status     = r_status;
        n_tframe     = r_tframe;
        n_mframe     = r_mframe;
        o_mem_req    = '0;
        w_pages_done = 1'b0;

        case (r_state)
            // Zero the whole memory; frame 0 is marked in use
            S_CLR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_clr;
                o_mem_req.wdata = (r_clr == '0) ? DW'(1) : '0;
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_proc   = i_in_word.proc_id;
                    n_count  = i_in_word.num_pages;
                    n_vpage  = i_in_word.virt_page;
                    n_status = 1'b0;
                    n_tframe = '0;
                    n_mframe = '0;
                    case (i_in_word.req_type)
                        pfa_pkg::REQ_NEW: begin
                            o_mem_req.raddr = '0;
                            n_cur    = '0;
                            n_tphase = 1'b1;
                            n_state  = S_N_CHK;
                        end
                        pfa_pkg::REQ_KILL: begin
                            o_mem_req.raddr = w_ptr_in;
                            n_state = S_K_PTR;
                        end
                        pfa_pkg::REQ_READ: begin
                            o_mem_req.raddr = w_ptr_in;
                            n_state = S_R_PTR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Free map scan: data is the flag of frame r_cur, next frame prefetched
            S_N_CHK: begin
                o_mem_req.raddr = AW'(w_cur_nx);
                if (i_mem_rdata == '0) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = AW'(r_cur);
                    o_mem_req.wdata = DW'(1);
                    n_state         = S_N_REC;
                end else if (r_cur == LAST_FRAME) begin
                    // out of frames
                    n_status = 1'b1;
                    if (r_tphase) begin
                        o_mem_req.we    = 1'b1;
                        o_mem_req.waddr = w_ptr_cur;
                        o_mem_req.wdata = '0;
                    end
                    n_state = S_DONE;
                end else begin
                    n_cur = w_cur_nx;
                end
            end

            // Record the frame just taken as table pointer or table entry
            S_N_REC: begin
                o_mem_req.raddr = AW'(w_cur_nx);
                o_mem_req.we    = 1'b1;
                o_mem_req.wdata = DW'(r_cur);
                if (r_tphase) begin
                    o_mem_req.waddr = w_ptr_cur;
                    n_tframe        = r_cur;
                    n_tab           = r_cur;
                    n_tphase        = 1'b0;
                    n_idx           = '0;
                    w_pages_done    = (r_count == '0);
                end else begin
                    o_mem_req.waddr = {r_tab, r_idx};
                    n_idx           = r_idx + 1'b1;
                    w_pages_done    = (r_idx == r_count - 1'b1);
                end
                if (w_pages_done) begin
                    n_state = S_DONE;
                end else if (r_cur == LAST_FRAME) begin
                    n_status = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_cur   = w_cur_nx;
                    n_state = S_N_CHK;
                end
            end

            // Kill: table pointer arrives
            S_K_PTR: begin
                if (i_mem_rdata == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_tab           = i_mem_rdata;
                    n_idx           = '0;
                    o_mem_req.raddr = {i_mem_rdata, BW'(0)};
                    n_state         = S_K_CHK;
                end
            end

            // Kill: entry r_idx arrives; free its frame if mapped
            S_K_CHK: begin
                if (i_mem_rdata != '0) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = AW'(i_mem_rdata);
                    o_mem_req.wdata = '0;
                    n_state         = S_K_CLR;
                end else if (r_idx == LAST_BYTE) begin
                    n_state = S_K_FREE;
                end else begin
                    o_mem_req.raddr = {r_tab, r_idx + 1'b1};
                    n_idx           = r_idx + 1'b1;
                end
            end

            // Kill: clear the entry, fetch the next one
            S_K_CLR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = {r_tab, r_idx};
                o_mem_req.wdata = '0;
                if (r_idx == LAST_BYTE) begin
                    n_state = S_K_FREE;
                end else begin
                    o_mem_req.raddr = {r_tab, r_idx + 1'b1};
                    n_idx           = r_idx + 1'b1;
                    n_state         = S_K_CHK;
                end
            end

            // Kill: release the table frame itself
            S_K_FREE: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = AW'(r_tab);
                o_mem_req.wdata = '0;
                n_tframe        = r_tab;
                n_state         = S_DONE;
            end

            // Read: table pointer arrives
            S_R_PTR: begin
                if (i_mem_rdata == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_tframe        = i_mem_rdata;
                    o_mem_req.raddr = {i_mem_rdata, r_vpage};
                    n_state         = S_R_ENT;
                end
            end

            S_R_ENT: begin
                n_mframe = i_mem_rdata;
                n_state  = S_DONE;
            end

            // Hand the result word to the output register
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_idx    <= n_idx;
        r_tab    <= n_tab;
        r_tphase <= n_tphase;
        r_proc   <= n_proc;
        r_count  <= n_count;
        r_vpage  <= n_vpage;
        r_status <= n_status;
        r_tframe <= n_tframe;
        r_mframe <= n_mframe;
    end

    assign o_in_stall               = (r_state != S_IDLE);
    assign o_res_valid              = (r_state == S_DONE);
    assign o_res_word.status        = r_status;
    assign o_res_word.table_frame   = r_tframe;
    assign o_res_word.mapped_frame  = r_mframe;

endmodule

// ===== rtl/page_frame_allocator_with_tables_core.sv =====
// Top level of the page frame allocator: sequencer, physical memory, output register.
//
// Input channel (i_in_valid / o_in_stall / i_in_word): one request word per
// accepted cycle: new process, kill process or read of one page table entry.
// Output channel (o_out_valid / i_out_stall / o_out_word): exactly one result
// word per request, in request order.
// Requests are handled one at a time by a sequencer around a single
// 16384 x 6 memory with registered read data (one read and one write port).
// A read fetches the table pointer, then the entry; a kill reads every one of
// the 256 entries, frees and clears each mapped one, then frees the table frame;
// a new process scans the free map (at most 64 frames) and records each frame taken.
// After reset the sequencer zeroes all 16384 memory words, one word per cycle,
// with o_in_stall high; frame 0 is marked in use by the same pass.
// A finished word waits in the output register while i_out_stall is high;
// the next request is taken meanwhile and its result waits in the sequencer
// until the register frees.
`timescale 1ns / 1ps

module page_frame_allocator_with_tables_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pfa_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pfa_pkg::t_out_word o_out_word
);

    pfa_pkg::t_mem_req          w_mem_req;
    logic [pfa_pkg::DATA_W-1:0] w_mem_rdata;
    logic                       w_res_valid;
    logic                       w_res_ready;
    pfa_pkg::t_out_word         w_res_word;

    logic                       r_out_valid;
    pfa_pkg::t_out_word         r_out_word;

    pfa_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_res_valid (w_res_valid),
        .o_res_word  (w_res_word),
        .i_res_ready (w_res_ready),
        .o_mem_req   (w_mem_req),
        .i_mem_rdata (w_mem_rdata)
    );

    pfa_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_mem_rdata)
    );

    // Output register: free when empty or being taken this cycle
    assign w_res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out_word <= w_res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== sim/page_frame_allocator_with_tables_core_test.sv =====
// Self-checking testbench for the page frame allocator core: directed and random requests.
`timescale 1ns / 1ps

module page_frame_allocator_with_tables_core_test;

    // Request code the block has no meaning for
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 600;
    localparam int RANDOM_WORDS = 925;
    localparam int FRAMES       = pfa_pkg::FRAME_COUNT;
    localparam int FBYTES       = pfa_pkg::FRAME_BYTES;

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    pfa_pkg::t_in_word  in_word = '0;
    logic               out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    pfa_pkg::t_out_word o_out_word;

    page_frame_allocator_with_tables_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the block's byte memory and the results it owes
    logic [7:0]         frame_mem [0:FRAMES*FBYTES-1];
    pfa_pkg::t_out_word awaited_results[$];
    pfa_pkg::t_in_word  pending_words[$];
    int                 errors = 0;
    int                 accepted_words = 0;
    longint             cycles = 0;
    bit                 word_taken = 1'b0;

    // Rough frame bookkeeping used only to steer the random requests
    bit gen_live [0:63];
    int gen_held [0:63];
    int gen_free;

    // Lowest free frame, marked in use; -1 when memory is full
    function automatic int grab_free_frame();
        int f;
        for (f = 0; f < FRAMES; f++) begin
            if (frame_mem[f] == 8'd0) begin
                frame_mem[f] = 8'd1;
                return f;
            end
        end
        return -1;
    endfunction

    // Table frame of a process, 0 when the pointer names none
    function automatic int table_frame_of(logic [5:0] proc);
        int v;
        v = int'(frame_mem[pfa_pkg::PTR_BASE + int'(proc)]);
        if (v == 0 || v >= FRAMES) return 0;
        return v;
    endfunction

    // Apply one request to the shadow memory and return the result it yields
    function automatic pfa_pkg::t_out_word serve_request(pfa_pkg::t_in_word w);
        pfa_pkg::t_out_word r;
        int                 tbl;
        int                 f;
        int                 n;
        r = '0;
        case (w.req_type)
            pfa_pkg::REQ_NEW: begin
                tbl = grab_free_frame();
                if (tbl < 0) begin
                    frame_mem[pfa_pkg::PTR_BASE + int'(w.proc_id)] = 8'd0;
                    r.status = 1'b1;
                end else begin
                    frame_mem[pfa_pkg::PTR_BASE + int'(w.proc_id)] = tbl[7:0];
                    r.table_frame = tbl[5:0];
                    for (n = 0; n < int'(w.num_pages); n++) begin
                        f = grab_free_frame();
                        if (f < 0) r.status = 1'b1;
                        else frame_mem[tbl*FBYTES + n] = f[7:0];
                    end
                end
            end
            pfa_pkg::REQ_KILL: begin
                tbl = table_frame_of(w.proc_id);
                if (tbl != 0) begin
                    for (n = 0; n < FBYTES; n++) begin
                        f = int'(frame_mem[tbl*FBYTES + n]);
                        if (f != 0) begin
                            if (f < FRAMES) frame_mem[f] = 8'd0;
                            frame_mem[tbl*FBYTES + n] = 8'd0;
                        end
                    end
                    frame_mem[tbl] = 8'd0;
                    r.table_frame = tbl[5:0];
                end
            end
            pfa_pkg::REQ_READ: begin
                tbl = table_frame_of(w.proc_id);
                if (tbl != 0) begin
                    r.table_frame = tbl[5:0];
                    f = int'(frame_mem[tbl*FBYTES + int'(w.virt_page)]);
                    if (f < FRAMES) r.mapped_frame = f[5:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic queue_request(logic [1:0] kind, int proc, int count, int vpage);
        pfa_pkg::t_in_word w;
        w.req_type  = kind;
        w.proc_id   = proc[5:0];
        w.num_pages = count[7:0];
        w.virt_page = vpage[7:0];
        pending_words.push_back(w);
    endtask

    // Random process whose tracked liveness matches, -1 if there is none
    function automatic int pick_proc(bit want_live);
        int s;
        int k;
        s = $urandom_range(63);
        for (k = 0; k < 64; k++) begin
            if (gen_live[(s + k) % 64] == want_live) return (s + k) % 64;
        end
        return -1;
    endfunction

    // Random idling, switched off over a long middle stretch
    function automatic bit idle_now();
        if (accepted_words >= 300 && accepted_words < 520) return 1'b0;
        return $urandom_range(99) < 9;
    endfunction

    task automatic report_mismatch(string what, int expected, int got);
        $display("MISMATCH %s: expected %0d got %0d (cycle %0d)", what, expected, got, cycles);
        errors++;
    endtask

    // Driver: next word after acceptance, payload held while stalled
    always @(negedge i_clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end else begin
            out_stall <= idle_now();
            if (!in_valid || word_taken) begin
                word_taken = 1'b0;
                if (pending_words.size() != 0 && !idle_now()) begin
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predict on each accepted request, check each delivered result
    always @(posedge i_clk) begin : watch
        pfa_pkg::t_out_word want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("page_frame_allocator_with_tables_core test failed");
            $finish;
        end
        if (rst_n && in_valid && !o_in_stall) begin
            awaited_results.push_back(serve_request(in_word));
            accepted_words++;
            word_taken = 1'b1;
        end
        if (rst_n && o_out_valid && !out_stall) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result word", 0, int'(o_out_word));
            end else begin
                want = awaited_results.pop_front();
                if (o_out_word.status != want.status)
                    report_mismatch("status", int'(want.status), int'(o_out_word.status));
                if (o_out_word.table_frame != want.table_frame)
                    report_mismatch("table_frame", int'(want.table_frame),
                                    int'(o_out_word.table_frame));
                if (o_out_word.mapped_frame != want.mapped_frame)
                    report_mismatch("mapped_frame", int'(want.mapped_frame),
                                    int'(o_out_word.mapped_frame));
            end
        end
    end

    initial begin
        int          n;
        int          roll;
        int          p;
        int          cnt;
        int          vp;
        int          take;
        logic [1:0]  kind;

        // Shadow memory matches the cleared block: only frame 0 in use
        for (n = 0; n < FRAMES*FBYTES; n++) frame_mem[n] = 8'd0;
        frame_mem[0] = 8'd1;

        // Directed: empty tables, unused code, double kill, exhaustion, overwrite
        queue_request(pfa_pkg::REQ_READ, 0, 0, 0);
        queue_request(REQ_UNUSED, 63, 255, 255);
        queue_request(pfa_pkg::REQ_KILL, 5, 0, 0);
        queue_request(pfa_pkg::REQ_NEW, 0, 0, 0);
        queue_request(pfa_pkg::REQ_NEW, 63, 3, 0);
        queue_request(pfa_pkg::REQ_READ, 63, 0, 0);
        queue_request(pfa_pkg::REQ_READ, 63, 0, 2);
        queue_request(pfa_pkg::REQ_READ, 63, 0, 3);
        queue_request(pfa_pkg::REQ_READ, 63, 255, 255);
        queue_request(pfa_pkg::REQ_KILL, 63, 0, 0);
        queue_request(pfa_pkg::REQ_READ, 63, 0, 0);
        queue_request(pfa_pkg::REQ_KILL, 63, 0, 0);
        queue_request(pfa_pkg::REQ_NEW, 1, 255, 0);
        queue_request(pfa_pkg::REQ_READ, 1, 0, 0);
        queue_request(pfa_pkg::REQ_READ, 1, 0, 60);
        queue_request(pfa_pkg::REQ_READ, 1, 0, 255);
        queue_request(pfa_pkg::REQ_NEW, 2, 1, 0);
        queue_request(pfa_pkg::REQ_READ, 2, 0, 0);
        queue_request(pfa_pkg::REQ_KILL, 1, 0, 0);
        queue_request(pfa_pkg::REQ_KILL, 0, 0, 0);
        queue_request(pfa_pkg::REQ_NEW, 7, 0, 0);
        queue_request(pfa_pkg::REQ_NEW, 7, 2, 0);
        queue_request(pfa_pkg::REQ_KILL, 7, 0, 0);
        queue_request(pfa_pkg::REQ_READ, 7, 0, 1);
        queue_request(pfa_pkg::REQ_READ, 42, 0, 170);

        // Random: mostly allocate, read back and free; some stale and stray requests
        for (n = 0; n < 64; n++) begin
            gen_live[n] = 1'b0;
            gen_held[n] = 0;
        end
        gen_free = 62;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            roll = $urandom_range(99);
            kind = roll < 5 ? REQ_UNUSED : roll < 35 ? pfa_pkg::REQ_NEW :
                   roll < 60 ? pfa_pkg::REQ_KILL : pfa_pkg::REQ_READ;
            if (kind == pfa_pkg::REQ_NEW && gen_free < 8 && $urandom_range(3) != 0)
                kind = pfa_pkg::REQ_KILL;
            case (kind)
                pfa_pkg::REQ_NEW: begin
                    p = pick_proc(1'b0);
                    if (p < 0 || $urandom_range(99) < 2) p = $urandom_range(63);
                    roll = $urandom_range(99);
                    cnt = roll < 70 ? $urandom_range(4, 1) :
                          roll < 93 ? $urandom_range(16) : $urandom_range(255);
                    take = (1 + cnt < gen_free) ? 1 + cnt : gen_free;
                    gen_free -= take;
                    gen_live[p] = take > 0;
                    gen_held[p] = take;
                    queue_request(pfa_pkg::REQ_NEW, p, cnt, $urandom_range(255));
                end
                pfa_pkg::REQ_KILL: begin
                    p = pick_proc(1'b1);
                    if (p < 0 || $urandom_range(99) < 10) p = $urandom_range(63);
                    if (gen_live[p]) begin
                        gen_free += gen_held[p];
                        gen_live[p] = 1'b0;
                    end
                    queue_request(pfa_pkg::REQ_KILL, p, $urandom_range(255),
                                  $urandom_range(255));
                end
                pfa_pkg::REQ_READ: begin
                    p = pick_proc(1'b1);
                    if (p >= 0 && $urandom_range(99) < 85) begin
                        vp = $urandom_range(gen_held[p]);
                    end else begin
                        p = $urandom_range(63);
                        vp = $urandom_range(255);
                    end
                    queue_request(pfa_pkg::REQ_READ, p, $urandom_range(255), vp);
                end
                default: begin
                    queue_request(REQ_UNUSED, $urandom_range(63), $urandom_range(255),
                                  $urandom_range(255));
                end
            endcase
        end

        repeat (10) @(negedge i_clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("page_frame_allocator_with_tables_core test passed");
        end else begin
            $display("page_frame_allocator_with_tables_core test failed");
        end
        $finish;
    end

endmodule
